[hw/rtl/sbs_pkg.sv]
// Shared constants, types and helpers for the sample block statistics block.
// No dependencies; compiled first.
package sbs_pkg;

  localparam int SAMPLE_W          = 16;
  localparam int COUNTER_WIDTH_DEF = 32;
  localparam int OUT_CNT_W         = 32;
  localparam int NUM_BUCKETS       = 8;
  localparam int BUCKET_W          = $clog2(NUM_BUCKETS);
  localparam int ACC_W             = 64;
  localparam int MAG_SHIFT         = 12;
  localparam int XOR_SHIFT         = 7;
  localparam int XOR_PATTERN_W     = 32;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [BUCKET_W-1:0]        bucket_t;
  typedef logic [ACC_W-1:0]           acc_t;

  // Fold operation chosen by the phase counter
  typedef enum logic [1:0] {
    PH_ADD  = 2'd0,
    PH_SUB3 = 2'd1,
    PH_ADD5 = 2'd2,
    PH_XOR  = 2'd3
  } phase_t;

  // Magnitude bucket: |v| >> 12, clamped to the last bucket
  function automatic bucket_t bucket_of(input sample_t v);
    logic [SAMPLE_W:0]            mag;
    logic [SAMPLE_W-MAG_SHIFT:0]  hi;
    begin
      mag = v[SAMPLE_W-1] ? -{v[SAMPLE_W-1], v} : {v[SAMPLE_W-1], v};
      hi  = mag[SAMPLE_W:MAG_SHIFT];
      if (hi > (SAMPLE_W-MAG_SHIFT+1)'(NUM_BUCKETS-1)) begin
        bucket_of = bucket_t'(NUM_BUCKETS-1);
      end else begin
        bucket_of = hi[BUCKET_W-1:0];
      end
    end
  endfunction

endpackage

[hw/rtl/sbs_if.sv]
// Valid/ready channel interfaces for samples in and bucket reports out.
// Depends on sbs_pkg.
interface sbs_sample_if;
  logic                    valid;
  logic                    ready;
  sbs_pkg::sample_t        sample;
  logic                    first_sample;
  logic                    last_sample;

  modport source  (output valid, sample, first_sample, last_sample, input ready);
  modport sink    (input valid, sample, first_sample, last_sample, output ready);
  modport monitor (input valid, ready, sample, first_sample, last_sample);
endinterface

interface sbs_result_if;
  logic                              valid;
  logic                              ready;
  sbs_pkg::bucket_t                  bucket_index;
  logic [sbs_pkg::OUT_CNT_W-1:0]     bucket_count;
  sbs_pkg::sample_t                  minimum_value;
  sbs_pkg::sample_t                  maximum_value;
  logic [sbs_pkg::SAMPLE_W-1:0]      value_span;
  logic [sbs_pkg::OUT_CNT_W-1:0]     sign_changes;
  logic signed [sbs_pkg::ACC_W-1:0]  weighted_total;
  logic                              last_of_run;

  modport source  (output valid, bucket_index, bucket_count, minimum_value, maximum_value,
                   value_span, sign_changes, weighted_total, last_of_run, input ready);
  modport sink    (input valid, bucket_index, bucket_count, minimum_value, maximum_value,
                   value_span, sign_changes, weighted_total, last_of_run, output ready);
  modport monitor (input valid, ready, bucket_index, bucket_count, minimum_value,
                   maximum_value, value_span, sign_changes, weighted_total, last_of_run);
endinterface

[hw/rtl/sample_block_statistics.sv]
// Per-block sample statistics: min/max, sign changes, magnitude histogram, weighted total.
// Depends on sbs_pkg and sbs_if (sbs_sample_if, sbs_result_if).
//
// Samples are taken one per cycle, except while a report is pending as described below. Each
// sample updates the running min/max, the sign change count and the phase-weighted 64-bit
// total in registers, and bumps one of eight histogram counters held in a small two-read-port
// memory (read at accept, incremented and written in the next cycle, with the previous write
// forwarded). A sample flagged last produces eight result beats, bucket 0 first; from its
// accept until the eighth bucket has left the read stage, the sample channel is not ready.
// The wait is set by the single emission read port walking the eight memory entries. A first
// flag clears the histogram at once through per-entry valid bits.
module sample_block_statistics #(
  parameter int COUNTER_WIDTH = sbs_pkg::COUNTER_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  sbs_sample_if.sink    samples,
  sbs_result_if.source  results
);
  import sbs_pkg::*;

  typedef logic [COUNTER_WIDTH-1:0] cnt_t;

  // Histogram memory
  cnt_t                 mem [NUM_BUCKETS];
  cnt_t                 rdata_upd;
  cnt_t                 rdata_emit;
  logic [NUM_BUCKETS-1:0] bvalid;

  // Scalar statistics
  sample_t              run_min, run_max;
  logic                 prev_neg;
  cnt_t                 sign_cnt;
  acc_t                 acc;
  phase_t               phase;

  // Update stage
  logic                 s1_valid;
  bucket_t              s1_bucket;
  logic                 s1_first;
  logic                 s1_last;
  logic                 wr_valid;
  bucket_t              wr_bucket;
  cnt_t                 wr_count;

  // Emission
  logic                 emit_active;
  bucket_t              emit_k;
  logic                 r_valid;
  bucket_t              r_k;
  logic                 o_valid;

  logic                 accept;
  logic                 r_load, o_load;
  sample_t              v;
  logic                 neg;
  bucket_t              in_bucket;
  cnt_t                 base_cnt, upd_cnt;
  cnt_t                 r_count;
  logic [OUT_CNT_W-1:0] r_count_out, sign_out;

  sample_t              min_base, max_base, min_next, max_next;
  logic                 prev_base;
  cnt_t                 sign_base, sign_next;
  acc_t                 acc_base, acc_next, vs;
  phase_t               phase_base, phase_next;

  assign samples.ready = !emit_active && !(s1_valid && s1_last) && !r_valid;
  assign accept        = samples.valid && samples.ready;
  assign v             = samples.sample;
  assign neg           = v[SAMPLE_W-1];
  assign in_bucket     = bucket_of(v);
  assign vs            = acc_t'(signed'(v));

  // Scalar next-state
  always_comb begin
    min_base   = samples.first_sample ? v : run_min;
    max_base   = samples.first_sample ? v : run_max;
    prev_base  = samples.first_sample ? neg : prev_neg;
    sign_base  = samples.first_sample ? '0 : sign_cnt;
    acc_base   = samples.first_sample ? '0 : acc;
    phase_base = samples.first_sample ? PH_ADD : phase;

    min_next = min_base;
    max_next = max_base;
    if (v < min_base) begin
      min_next = v;
    end else if (v > max_base) begin
      max_next = v;
    end

    sign_next = (neg != prev_base) ? sign_base + cnt_t'(1) : sign_base;

    case (phase_base)
      PH_ADD:  acc_next = acc_base + vs;
      PH_SUB3: acc_next = acc_base - ((vs << 1) + vs);
      PH_ADD5: acc_next = acc_base + ((vs << 2) + vs);
      // 32-bit pattern of the sample, zero-extended
      PH_XOR:  acc_next = acc_base ^
                          ({{(ACC_W-XOR_PATTERN_W){1'b0}}, XOR_PATTERN_W'(signed'(v))}
                           << XOR_SHIFT);
      default: acc_next = acc_base;
    endcase
    phase_next = phase_t'(phase_base + 2'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_min  <= '0;
      run_max  <= '0;
      prev_neg <= 1'b0;
      sign_cnt <= '0;
      acc      <= '0;
      phase    <= PH_ADD;
    end else if (accept) begin
      run_min  <= min_next;
      run_max  <= max_next;
      prev_neg <= neg;
      sign_cnt <= sign_next;
      acc      <= acc_next;
      phase    <= phase_next;
    end
  end

  // Counter read-modify-write; the previous write is not yet visible in rdata_upd
  always_comb begin
    if (s1_first) begin
      base_cnt = '0;
    end else if (wr_valid && wr_bucket == s1_bucket) begin
      base_cnt = wr_count;
    end else if (bvalid[s1_bucket]) begin
      base_cnt = rdata_upd;
    end else begin
      base_cnt = '0;
    end
    upd_cnt = base_cnt + cnt_t'(1);
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      mem[s1_bucket] <= upd_cnt;
    end
    if (accept) begin
      rdata_upd <= mem[in_bucket];
    end
    if (r_load) begin
      rdata_emit <= mem[emit_k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      wr_valid <= 1'b0;
      bvalid   <= '0;
    end else begin
      s1_valid <= accept;
      wr_valid <= s1_valid;
      if (s1_valid) begin
        if (s1_first) begin
          bvalid <= NUM_BUCKETS'(1) << s1_bucket;
        end else begin
          bvalid[s1_bucket] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_bucket <= in_bucket;
      s1_first  <= samples.first_sample;
      s1_last   <= samples.last_sample;
    end
    if (s1_valid) begin
      wr_bucket <= s1_bucket;
      wr_count  <= upd_cnt;
    end
  end

  // Emission: read stage then output register
  assign o_load  = r_valid && (!o_valid || results.ready);
  assign r_load  = emit_active && (!r_valid || o_load);
  assign r_count = bvalid[r_k] ? rdata_emit : '0;

  if (COUNTER_WIDTH >= OUT_CNT_W) begin : g_wide
    assign r_count_out = r_count[OUT_CNT_W-1:0];
    assign sign_out    = sign_cnt[OUT_CNT_W-1:0];
  end else begin : g_narrow
    assign r_count_out = {{(OUT_CNT_W-COUNTER_WIDTH){1'b0}}, r_count};
    assign sign_out    = {{(OUT_CNT_W-COUNTER_WIDTH){1'b0}}, sign_cnt};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      emit_active <= 1'b0;
      emit_k      <= '0;
      r_valid     <= 1'b0;
      o_valid     <= 1'b0;
    end else begin
      if (s1_valid && s1_last) begin
        emit_active <= 1'b1;
      end else if (r_load && emit_k == bucket_t'(NUM_BUCKETS-1)) begin
        emit_active <= 1'b0;
      end
      if (r_load) begin
        emit_k <= emit_k + bucket_t'(1);
      end

      if (r_load) begin
        r_valid <= 1'b1;
      end else if (o_load) begin
        r_valid <= 1'b0;
      end

      if (o_load) begin
        o_valid <= 1'b1;
      end else if (results.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (r_load) begin
      r_k <= emit_k;
    end
    if (o_load) begin
      results.bucket_index   <= r_k;
      results.bucket_count   <= r_count_out;
      results.minimum_value  <= run_min;
      results.maximum_value  <= run_max;
      results.value_span     <= SAMPLE_W'(run_max - run_min);
      results.sign_changes   <= sign_out;
      results.weighted_total <= acc;
      results.last_of_run    <= (r_k == bucket_t'(NUM_BUCKETS-1));
    end
  end

  assign results.valid = o_valid;

endmodule

[hw/rtl/sbs_checker.sv]
// Port-level checks for sample_block_statistics, attached by bind.
// Depends on sbs_pkg and sbs_if.
module sbs_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           samples_valid,
  input logic                           samples_ready,
  input logic                           samples_last,
  input logic                           results_valid,
  input logic                           results_ready,
  input sbs_pkg::bucket_t               bucket_index,
  input logic [sbs_pkg::OUT_CNT_W-1:0]  bucket_count,
  input sbs_pkg::sample_t               minimum_value,
  input sbs_pkg::sample_t               maximum_value,
  input logic [sbs_pkg::SAMPLE_W-1:0]   value_span,
  input logic [sbs_pkg::ACC_W-1:0]      weighted_total,
  input logic                           last_of_run
);
  import sbs_pkg::*;

  // A stalled result beat holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    results_valid && !results_ready |=>
      results_valid && $stable(bucket_index) && $stable(bucket_count)
      && $stable(weighted_total))
    else $error("result beat changed while stalled");

  // Last sample closes the sample channel while the report is built
  a_last_blocks: assert property (@(posedge clk) disable iff (rst)
    samples_valid && samples_ready && samples_last |=> !samples_ready)
    else $error("sample taken right after a last sample");

  // No sample is taken while the report still shows a bucket before its last
  a_report_blocks: assert property (@(posedge clk) disable iff (rst)
    results_valid && !last_of_run |-> !samples_ready)
    else $error("sample channel ready in the middle of a report");

  // Run marker sits on the final bucket only
  a_last_bucket: assert property (@(posedge clk) disable iff (rst)
    results_valid |-> (last_of_run == (bucket_index == bucket_t'(NUM_BUCKETS-1))))
    else $error("last_of_run on wrong bucket");

  // Span agrees with the reported extremes
  a_span: assert property (@(posedge clk) disable iff (rst)
    results_valid |->
      value_span == SAMPLE_W'(maximum_value - minimum_value))
    else $error("value_span mismatch");

endmodule

bind sample_block_statistics sbs_checker u_sbs_checker (
  .clk            (clk),
  .rst            (rst),
  .samples_valid  (samples.valid),
  .samples_ready  (samples.ready),
  .samples_last   (samples.last_sample),
  .results_valid  (results.valid),
  .results_ready  (results.ready),
  .bucket_index   (results.bucket_index),
  .bucket_count   (results.bucket_count),
  .minimum_value  (results.minimum_value),
  .maximum_value  (results.maximum_value),
  .value_span     (results.value_span),
  .weighted_total (results.weighted_total),
  .last_of_run    (results.last_of_run)
);
